// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check c in the cycle after a
`define FIRL_ASSERT_NEXT(lbl, clk_s, rst_n_s, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (a) |=> (c)) \
		else $error("interlock assertion failed");

// check c in the same cycle as a
`define FIRL_ASSERT_SAME(lbl, clk_s, rst_n_s, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (a) |-> (c)) \
		else $error("interlock assertion failed");

`endif

// ===== rtl/core/firl_pkg.sv =====
`timescale 1ns / 1ps
package firl_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 16;
	localparam int unsigned WINDOW_MS_DEF = 60000;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_Y = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ENABLE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRE_DURATION = 4'd7;

	localparam logic [1:0] LINK_OK = 2'd0;
	localparam logic [1:0] LINK_TRANSPORT = 2'd1;
	localparam logic [1:0] LINK_DOWN = 2'd2;
	localparam logic [1:0] LINK_REFUSED = 2'd3;

	localparam logic REQ_AUTHORISE = 1'b0;
	localparam logic REQ_SENT = 1'b1;

	typedef enum logic [3:0] {
		REF_NONE = 4'd0,
		REF_UNCONFIRMED = 4'd1,
		REF_TRANSPORT = 4'd2,
		REF_UNAVAILABLE = 4'd3,
		REF_REJECTED = 4'd4,
		REF_NO_ENVELOPE = 4'd5,
		REF_ZONE = 4'd6,
		REF_COOLING = 4'd7,
		REF_RATE = 4'd8
	} refusal_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT,
		ST_STORE
	} state_t;

	typedef struct packed {
		logic req_type;
		logic [31:0] now_ms;
		logic intent_fire;
		logic [1:0] link_status;
		logic signed [15:0] aim_x;
		logic signed [15:0] aim_y;
	} in_item_t;

	typedef struct packed {
		logic granted;
		refusal_t refusal_code;
		logic signed [15:0] grant_x;
		logic signed [15:0] grant_y;
		logic [15:0] grant_duration_ms;
	} out_item_t;

	typedef struct packed {
		logic [31:0] envelope_x_range;
		logic [31:0] envelope_y_range;
		logic [31:0] zone_x_range;
		logic [31:0] zone_y_range;
		logic zone_enable;
		logic [31:0] quiet_ms;
		logic [4:0] max_per_window;
		logic [15:0] fire_duration_ms;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic rd_issue;
		logic emit;
		logic store;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_sent;
		logic early_refuse;
		logic walk_last;
	} dp_status_t;

endpackage

// ===== rtl/core/firl_cfg_regs.sv =====
`timescale 1ns / 1ps
module firl_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [firl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output firl_pkg::cfg_t cfg
);

	firl_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				firl_pkg::CFG_ENVELOPE_X: cfg_q.envelope_x_range <= cfg_data;
				firl_pkg::CFG_ENVELOPE_Y: cfg_q.envelope_y_range <= cfg_data;
				firl_pkg::CFG_ZONE_X: cfg_q.zone_x_range <= cfg_data;
				firl_pkg::CFG_ZONE_Y: cfg_q.zone_y_range <= cfg_data;
				firl_pkg::CFG_ZONE_ENABLE: cfg_q.zone_enable <= cfg_data[0];
				firl_pkg::CFG_QUIET: cfg_q.quiet_ms <= cfg_data;
				firl_pkg::CFG_MAX_PER_WINDOW: cfg_q.max_per_window <= cfg_data[4:0];
				firl_pkg::CFG_FIRE_DURATION: cfg_q.fire_duration_ms <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/firl_ctrl.sv =====
`timescale 1ns / 1ps
module firl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input firl_pkg::dp_status_t status,
	output firl_pkg::ctrl_cmd_t cmd
);

	firl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= firl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			firl_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = firl_pkg::ST_CHECK;
				end
			end
			firl_pkg::ST_CHECK: begin
				if (!status.is_sent && status.early_refuse) begin
					state_d = firl_pkg::ST_RESULT;
				end else begin
					state_d = firl_pkg::ST_WALK;
				end
			end
			firl_pkg::ST_WALK: begin
				cmd.rd_issue = 1'b1;
				if (status.walk_last) begin
					state_d = firl_pkg::ST_DRAIN;
				end
			end
			firl_pkg::ST_DRAIN: begin
				state_d = status.is_sent ? firl_pkg::ST_STORE : firl_pkg::ST_RESULT;
			end
			firl_pkg::ST_RESULT: begin
				cmd.emit = 1'b1;
				state_d = firl_pkg::ST_IDLE;
			end
			firl_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				state_d = firl_pkg::ST_IDLE;
			end
			default: begin
				state_d = firl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/firl_datapath.sv =====
`timescale 1ns / 1ps
module firl_datapath #(
	parameter int unsigned HISTORY_DEPTH = firl_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned WINDOW_MS = firl_pkg::WINDOW_MS_DEF
) (
	input logic clk,
	input logic arst_n,
	input firl_pkg::in_item_t in_item,
	input firl_pkg::cfg_t cfg,
	input firl_pkg::ctrl_cmd_t cmd,
	output firl_pkg::dp_status_t status,
	output logic result_valid,
	output firl_pkg::out_item_t result
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [31:0] WIN = 32'(WINDOW_MS);

	logic [31:0] mem [HISTORY_DEPTH];

	firl_pkg::in_item_t item_q;
	logic [HISTORY_DEPTH-1:0] send_valid_q;
	logic [IDX_W-1:0] newest_q;
	logic [IDX_W-1:0] write_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic cool_q;
	logic eval_en_s1;
	logic [IDX_W-1:0] eval_idx_s1;
	logic [31:0] rd_data_s1;
	logic result_valid_q;
	firl_pkg::out_item_t result_q;

	logic signed [15:0] env_x_lo, env_x_hi, env_y_lo, env_y_hi;
	logic signed [15:0] zone_x_lo, zone_x_hi, zone_y_lo, zone_y_hi;
	logic signed [15:0] gx, gy;
	logic env_empty, in_zone;
	firl_pkg::refusal_t early_code, final_code;
	logic [31:0] age, horizon;
	logic hit_valid;
	logic [CMP_W-1:0] count_ext, max_ext;

	assign env_x_lo = $signed(cfg.envelope_x_range[15:0]);
	assign env_x_hi = $signed(cfg.envelope_x_range[31:16]);
	assign env_y_lo = $signed(cfg.envelope_y_range[15:0]);
	assign env_y_hi = $signed(cfg.envelope_y_range[31:16]);
	assign zone_x_lo = $signed(cfg.zone_x_range[15:0]);
	assign zone_x_hi = $signed(cfg.zone_x_range[31:16]);
	assign zone_y_lo = $signed(cfg.zone_y_range[15:0]);
	assign zone_y_hi = $signed(cfg.zone_y_range[31:16]);

	always_comb begin
		gx = item_q.aim_x;
		if (item_q.aim_x < env_x_lo) begin
			gx = env_x_lo;
		end else if (item_q.aim_x > env_x_hi) begin
			gx = env_x_hi;
		end
		gy = item_q.aim_y;
		if (item_q.aim_y < env_y_lo) begin
			gy = env_y_lo;
		end else if (item_q.aim_y > env_y_hi) begin
			gy = env_y_hi;
		end
	end

	assign env_empty = (env_x_lo > env_x_hi) || (env_y_lo > env_y_hi);
	assign in_zone = cfg.zone_enable && (gx >= zone_x_lo) && (gx <= zone_x_hi)
		&& (gy >= zone_y_lo) && (gy <= zone_y_hi);

	always_comb begin
		priority if (!item_q.intent_fire) begin
			early_code = firl_pkg::REF_UNCONFIRMED;
		end else if (item_q.link_status == firl_pkg::LINK_TRANSPORT) begin
			early_code = firl_pkg::REF_TRANSPORT;
		end else if (item_q.link_status == firl_pkg::LINK_DOWN) begin
			early_code = firl_pkg::REF_UNAVAILABLE;
		end else if (item_q.link_status == firl_pkg::LINK_REFUSED) begin
			early_code = firl_pkg::REF_REJECTED;
		end else if (env_empty) begin
			early_code = firl_pkg::REF_NO_ENVELOPE;
		end else if (in_zone) begin
			early_code = firl_pkg::REF_ZONE;
		end else begin
			early_code = firl_pkg::REF_NONE;
		end
	end

	assign count_ext = CMP_W'(count_q);
	assign max_ext = CMP_W'(cfg.max_per_window);

	always_comb begin
		priority if (early_code != firl_pkg::REF_NONE) begin
			final_code = early_code;
		end else if (cool_q) begin
			final_code = firl_pkg::REF_COOLING;
		end else if (count_ext >= max_ext) begin
			final_code = firl_pkg::REF_RATE;
		end else begin
			final_code = firl_pkg::REF_NONE;
		end
	end

	assign age = item_q.now_ms - rd_data_s1;
	assign horizon = (cfg.quiet_ms > WIN) ? cfg.quiet_ms : WIN;
	assign hit_valid = send_valid_q[eval_idx_s1];

	assign status.is_sent = (item_q.req_type == firl_pkg::REQ_SENT);
	assign status.early_refuse = (early_code != firl_pkg::REF_NONE);
	assign status.walk_last = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid_q <= '0;
			newest_q <= '0;
			write_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			cool_q <= 1'b0;
			eval_en_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			eval_en_s1 <= cmd.rd_issue;
			result_valid_q <= cmd.emit;
			if (cmd.load) begin
				idx_q <= '0;
				count_q <= '0;
				cool_q <= 1'b0;
			end else if (cmd.rd_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (eval_en_s1 && hit_valid) begin
				if (status.is_sent) begin
					if (age >= horizon) begin
						send_valid_q[eval_idx_s1] <= 1'b0;
					end
				end else begin
					if (age < WIN) begin
						count_q <= count_q + 1'b1;
					end
					if ((eval_idx_s1 == newest_q) && (age < cfg.quiet_ms)) begin
						cool_q <= 1'b1;
					end
				end
			end
			if (cmd.store) begin
				send_valid_q[write_q] <= 1'b1;
				newest_q <= write_q;
				write_q <= (write_q == LAST_IDX) ? '0 : write_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[idx_q];
			eval_idx_s1 <= idx_q;
		end
		if (cmd.store) begin
			mem[write_q] <= item_q.now_ms;
		end
		if (cmd.emit) begin
			result_q.granted <= (final_code == firl_pkg::REF_NONE);
			result_q.refusal_code <= final_code;
			result_q.grant_x <= (final_code == firl_pkg::REF_NONE) ? gx : '0;
			result_q.grant_y <= (final_code == firl_pkg::REF_NONE) ? gy : '0;
			result_q.grant_duration_ms <= (final_code == firl_pkg::REF_NONE)
				? cfg.fire_duration_ms : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/core/fire_interlock_rate_limiter_top.sv =====
`timescale 1ns / 1ps
// Fire interlock with sliding-window rate limit and cool-down.
// Input channel: raise start with in_item while busy is low; the transaction is
// taken at that clock edge and busy rises on the next cycle.
// An authorise request yields one result on result, marked by result_valid for
// exactly one cycle; a fire-sent event yields no result.
// An authorise request refused by intent, link, envelope or zone passes from
// acceptance through CHECK and RESULT to the registered result strobe. Any
// other request walks the send-time store, one entry per cycle through its
// registered read port, then passes DRAIN and RESULT. A fire-sent event walks
// the store too and ends in STORE with the write of the new send time.
// busy is low again in the cycle the result strobe shows, so the next start
// may be taken then.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while busy is low. Indexes beyond the register list are ignored.
// Reset clears the configuration and control registers, the send-valid bits and
// the slot pointers; the send-time memory is not cleared and needs no clearing pass.
// The receiver cannot stall: a result is present for one cycle only.
`include "assert_macros.svh"
module fire_interlock_rate_limiter_top #(
	parameter int unsigned HISTORY_DEPTH = firl_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned WINDOW_MS = firl_pkg::WINDOW_MS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input firl_pkg::in_item_t in_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [firl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic result_valid,
	output firl_pkg::out_item_t result
);

	firl_pkg::cfg_t cfg;
	firl_pkg::ctrl_cmd_t cmd;
	firl_pkg::dp_status_t status;

	firl_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	firl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.status(status),
		.cmd(cmd)
	);

	firl_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.WINDOW_MS(WINDOW_MS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.cfg(cfg),
		.cmd(cmd),
		.status(status),
		.result_valid(result_valid),
		.result(result)
	);

	`FIRL_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	`FIRL_ASSERT_NEXT(a_strobe_single, clk, arst_n, result_valid, !result_valid)
	`FIRL_ASSERT_SAME(a_grant_code, clk, arst_n, result_valid,
		result.granted == (result.refusal_code == firl_pkg::REF_NONE))
	`FIRL_ASSERT_SAME(a_refused_zero, clk, arst_n, result_valid && !result.granted,
		result.grant_duration_ms == 16'd0 && result.grant_x == 16'sd0)
	`FIRL_ASSERT_NEXT(a_emit_strobe, clk, arst_n, cmd.emit, result_valid && !busy)

endmodule
